@@ hw/rtl/esd_pkg.sv @@
// Shared constants, types and month table for the epoch seconds to date converter.
package esd_pkg;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [25:0] RECIP_675      = 26'd50903317;
  localparam logic [16:0] RECIP_1461     = 17'd91868;
  localparam logic [16:0] RECIP_7        = 17'd74899;
  localparam logic [15:0] DAYS_1968_1970 = 16'd731;
  localparam logic [15:0] DAY_MAR_2100   = 16'd47541;
  localparam logic [15:0] WEEKDAY_OFFSET = 16'd3;
  localparam logic [15:0] QUAD_DAYS      = 16'd1461;
  localparam logic [11:0] BASE_YEAR      = 12'd1968;
  localparam logic [10:0] YEAR1_START    = 11'd366;
  localparam logic [10:0] YEAR2_START    = 11'd731;
  localparam logic [10:0] YEAR3_START    = 11'd1096;

  typedef logic [15:0] days_t;

  typedef struct packed {
    days_t days;
    logic  late;
  } qent_t;

  typedef struct packed {
    logic [2:0]  day_of_week;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_number;
  } date_t;

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic bump;
    bump = leap && (m >= 4'd2);
    return MONTH_START[m] + {8'd0, bump};
  endfunction

endpackage

@@ hw/rtl/esd_front.sv @@
// Front end: accepts seconds, converts to a day count and tags dates past February 2100.
module esd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_epoch_seconds,
  output logic               push,
  output esd_pkg::qent_t     push_data,
  input  logic               q_full
);

  logic                 f_valid_r;
  logic                 f_valid_nxt;
  esd_pkg::qent_t       f_ent_r;
  logic [50:0]          prod;
  esd_pkg::days_t       days;
  logic                 adv;

  // days = secs / 86400 = (secs >> 7) / 675 by reciprocal
  assign prod = 51'(in_epoch_seconds[31:7]) * 51'(esd_pkg::RECIP_675);
  assign days = prod[50:35];

  assign adv         = !f_valid_r || !q_full;
  assign in_stall    = !adv;
  assign push        = f_valid_r && !q_full;
  assign push_data   = f_ent_r;
  assign f_valid_nxt = adv ? in_valid : f_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      f_ent_r.days <= days;
      f_ent_r.late <= (days >= esd_pkg::DAY_MAR_2100);
    end
  end

endmodule

@@ hw/rtl/esd_fifo.sv @@
// Short request queue between the front end and the back end.
module esd_fifo #(
  parameter int unsigned DEPTH = esd_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  esd_pkg::qent_t  push_data,
  output logic            full,
  input  logic            pop,
  output esd_pkg::qent_t  pop_data,
  output logic            empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  esd_pkg::qent_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/esd_back.sv @@
// Back end: five-stage pipeline from day count to weekday, day, month and year.
module esd_back (
  input  logic            clk,
  input  logic            rst_n,
  output logic            pop,
  input  esd_pkg::qent_t  pop_data,
  input  logic            q_empty,
  output logic            out_valid,
  input  logic            out_stall,
  output esd_pkg::date_t  out_date
);

  typedef struct packed {
    logic [15:0] dpp;
    logic [15:0] x7;
    logic [12:0] q7;
  } st1_t;

  typedef struct packed {
    logic [15:0] dpp;
    logic [5:0]  quad;
    logic [2:0]  dow;
  } st2_t;

  typedef struct packed {
    logic [10:0] r;
    logic [5:0]  quad;
    logic [2:0]  dow;
  } st3_t;

  typedef struct packed {
    logic [8:0]  doy;
    logic        leap;
    logic [11:0] year;
    logic [2:0]  dow;
  } st4_t;

  logic [4:0]     v_r, v_nxt;
  logic           adv;
  st1_t           s1_r, s1_nxt;
  st2_t           s2_r, s2_nxt;
  st3_t           s3_r, s3_nxt;
  st4_t           s4_r, s4_nxt;
  esd_pkg::date_t out_r, out_nxt;
  logic [32:0]    p7, p1461;
  logic [15:0]    rem7;
  logic [1:0]     yi;
  logic [10:0]    ybase;
  logic [3:0]     mon;

  assign adv       = !v_r[4] || !out_stall;
  assign pop       = adv && !q_empty;
  assign out_valid = v_r[4];
  assign out_date  = out_r;
  assign v_nxt     = adv ? {v_r[3:0], !q_empty} : v_r;

  // stage 1: shift to a 1968 base, insert a phantom 29 Feb 2100, weekday quotient
  always_comb begin
    s1_nxt.dpp = pop_data.days + esd_pkg::DAYS_1968_1970 + {15'd0, pop_data.late};
    s1_nxt.x7  = pop_data.days + esd_pkg::WEEKDAY_OFFSET;
    p7         = 33'(s1_nxt.x7) * 33'(esd_pkg::RECIP_7);
    s1_nxt.q7  = p7[31:19];
  end

  // stage 2: four-year block number and weekday
  always_comb begin
    p1461          = 33'(s1_r.dpp) * 33'(esd_pkg::RECIP_1461);
    s2_nxt.dpp     = s1_r.dpp;
    s2_nxt.quad    = p1461[32:27];
    rem7           = s1_r.x7 - 16'({3'd0, s1_r.q7} * 16'd7);
    s2_nxt.dow     = rem7[2:0] + 3'd1;
  end

  // stage 3: day within the block
  always_comb begin
    s3_nxt.r    = 11'(s2_r.dpp - 16'({10'd0, s2_r.quad} * esd_pkg::QUAD_DAYS));
    s3_nxt.quad = s2_r.quad;
    s3_nxt.dow  = s2_r.dow;
  end

  // stage 4: year within the block and day of year
  always_comb begin
    if (s3_r.r >= esd_pkg::YEAR3_START) begin
      yi    = 2'd3;
      ybase = esd_pkg::YEAR3_START;
    end else if (s3_r.r >= esd_pkg::YEAR2_START) begin
      yi    = 2'd2;
      ybase = esd_pkg::YEAR2_START;
    end else if (s3_r.r >= esd_pkg::YEAR1_START) begin
      yi    = 2'd1;
      ybase = esd_pkg::YEAR1_START;
    end else begin
      yi    = 2'd0;
      ybase = '0;
    end
    s4_nxt.doy  = 9'(s3_r.r - ybase);
    s4_nxt.leap = (yi == 2'd0);
    s4_nxt.year = esd_pkg::BASE_YEAR + {4'd0, s3_r.quad, 2'b00} + {10'd0, yi};
    s4_nxt.dow  = s3_r.dow;
  end

  // stage 5: month and day of month
  always_comb begin
    mon = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s4_r.doy >= esd_pkg::month_start(s4_r.leap, 4'(m))) begin
        mon = 4'(m);
      end
    end
    out_nxt.day_of_week  = s4_r.dow;
    out_nxt.day_of_month = 5'(s4_r.doy - esd_pkg::month_start(s4_r.leap, mon)) + 5'd1;
    out_nxt.month_number = mon + 4'd1;
    out_nxt.year_number  = s4_r.year;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

@@ hw/rtl/epoch_seconds_to_date.sv @@
// Top level of the epoch seconds to calendar date converter.
// Usage:
//   Input channel: present a 32-bit count of seconds since 1970-01-01 UTC on
//   in_epoch_seconds with in_valid; the request is taken at a clock edge where
//   in_valid is high and in_stall is low.
//   Output channel: out_valid flags a date on out_day_of_week (1 Monday to
//   7 Sunday), out_day_of_month, out_month_number and out_year_number; it is
//   taken at an edge where out_valid is high and out_stall is low.
// Timing:
//   One request per cycle is accepted while the output is not stalled.
//   From the accepting edge a request passes the front-end register, which
//   takes the 25x26 reciprocal quotient at that edge, then the queue, then
//   five back-end stages (weekday quotient, block reciprocal, block remainder,
//   year split, month search into the output).
//   The depth of the queue (FIFO_DEPTH) sets how many requests the front end
//   can hand over while the back end is held.
// Reset: synchronous, active low; empties the pipeline and the queue.
// Stall: a stalled output holds its date; the back end holds, the queue fills,
//   and then in_stall rises.
module epoch_seconds_to_date #(
  parameter int unsigned FIFO_DEPTH = esd_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_day_of_week,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_number,
  output logic [11:0] out_year_number
);

  logic            push, q_full, pop, q_empty;
  esd_pkg::qent_t  push_data, pop_data;
  esd_pkg::date_t  out_date;

  esd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .push             (push),
    .push_data        (push_data),
    .q_full           (q_full)
  );

  esd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  esd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_empty   (q_empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_date  (out_date)
  );

  assign out_day_of_week  = out_date.day_of_week;
  assign out_day_of_month = out_date.day_of_month;
  assign out_month_number = out_date.month_number;
  assign out_year_number  = out_date.year_number;

endmodule

@@ hw/rtl/esd_checker.sv @@
// Port-level checker for the converter and its bind to the top level.
module esd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_day_of_week,
  input logic [4:0]  out_day_of_month,
  input logic [3:0]  out_month_number,
  input logic [11:0] out_year_number
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_day_of_week) &&
      $stable(out_day_of_month) && $stable(out_month_number) && $stable(out_year_number))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_day_of_week >= 3'd1 && out_day_of_week <= 3'd7)
    else $error("weekday out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month_number >= 4'd1 && out_month_number <= 4'd12 &&
      out_day_of_month >= 5'd1 && out_year_number >= 12'd1970 &&
      out_year_number <= 12'd2106)
    else $error("date out of range");

endmodule

bind epoch_seconds_to_date esd_checker u_esd_checker (.*);
